/* rtl/vrt_pkg.sv */
// ----------------------------------------------------------------------------
// vrt_pkg
// Shared constants, register codes and types of the vertex transform unit.
// ----------------------------------------------------------------------------
package vrt_pkg;

    localparam int COORD_WIDTH_DEF    = 32;
    localparam int COEF_FRAC_BITS_DEF = 14;
    localparam int AXIS_W             = 16;
    localparam int AXIS_FRAC          = 14;
    localparam int ANGLE_W            = 13;
    localparam int CFG_INDEX_W        = 3;
    localparam int CORDIC_STEPS       = 20;
    localparam int CORDIC_FRAC        = 28;
    localparam int CORDIC_W           = 32;
    localparam int CORDIC_START       = 163008218;
    localparam int FULL_TURN          = 5760;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_MODE     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_AXIS_X   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_AXIS_Y   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_AXIS_Z   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ANGLE    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_DISTANCE = 3'd5;

    // Transform selected by the mode register.
    localparam logic MODE_ROTATE    = 1'b0;
    localparam logic MODE_TRANSLATE = 1'b1;

    // Status from the matrix builder to the datapath control.
    typedef struct packed {
        logic busy;
        logic mode;
    } build_status_t;

    // Arctangent of 2^-i in units of 2^-20 degree.
    function automatic logic signed [CORDIC_W-1:0] cordic_atan(input logic [4:0] i);
        logic signed [CORDIC_W-1:0] r;
        begin
            case (i)
                5'd0:    r = 32'sd47185920;
                5'd1:    r = 32'sd27855475;
                5'd2:    r = 32'sd14718068;
                5'd3:    r = 32'sd7471121;
                5'd4:    r = 32'sd3750058;
                5'd5:    r = 32'sd1876857;
                5'd6:    r = 32'sd938658;
                5'd7:    r = 32'sd469357;
                5'd8:    r = 32'sd234682;
                5'd9:    r = 32'sd117342;
                5'd10:   r = 32'sd58671;
                5'd11:   r = 32'sd29335;
                5'd12:   r = 32'sd14668;
                5'd13:   r = 32'sd7334;
                5'd14:   r = 32'sd3667;
                5'd15:   r = 32'sd1833;
                5'd16:   r = 32'sd917;
                5'd17:   r = 32'sd458;
                5'd18:   r = 32'sd229;
                5'd19:   r = 32'sd115;
                default: r = 32'sd0;
            endcase
            return r;
        end
    endfunction

endpackage

/* rtl/vrt_builder.sv */
// ----------------------------------------------------------------------------
// vrt_builder
// Configuration registers and the sequencer that builds the rotation matrix
// (CORDIC sine and cosine, then each coefficient through the ST_MULA and
// ST_MULB states) and the translation offsets.
// ----------------------------------------------------------------------------
module vrt_builder #(
    parameter int COORD_WIDTH    = vrt_pkg::COORD_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = vrt_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       cfg_valid,
    output logic                                       cfg_ready,
    input  logic [vrt_pkg::CFG_INDEX_W-1:0]            cfg_index,
    input  logic [COORD_WIDTH-1:0]                     cfg_data,
    output logic [8:0][COEF_FRAC_BITS+1:0]             coef_o,
    output logic [2:0][COORD_WIDTH+1:0]                offset_o,
    output vrt_pkg::build_status_t                     status_o
);
    import vrt_pkg::*;

    localparam int CF  = COEF_FRAC_BITS + 2;
    localparam int TW  = COEF_FRAC_BITS + 3;
    localparam int SH  = CORDIC_FRAC - COEF_FRAC_BITS;
    localparam int VW  = COEF_FRAC_BITS + 36;
    localparam int PW  = COORD_WIDTH + AXIS_W;
    localparam int SPW = AXIS_W + CF;
    localparam int OW  = COORD_WIDTH + 2;

    localparam logic signed [CORDIC_W-1:0] ONE_C  = CORDIC_W'(64'd1 << COEF_FRAC_BITS);
    localparam logic signed [CORDIC_W-1:0] RND_C  = CORDIC_W'(64'd1 << (SH - 1));
    localparam logic signed [VW-1:0]       RND_V  = VW'(64'd1 << (2 * AXIS_FRAC - 1));
    localparam logic signed [VW-1:0]       LIM_HI = VW'((64'd1 << (COEF_FRAC_BITS + 1)) - 64'd1);
    localparam logic signed [VW-1:0]       LIM_LO = -VW'(64'd1 << (COEF_FRAC_BITS + 1));
    localparam logic signed [PW-1:0]       RND_P  = PW'(64'd1 << (AXIS_FRAC - 1));

    typedef enum logic [2:0] {
        ST_IDLE, ST_LOAD, ST_CORDIC, ST_ROUND, ST_MULA, ST_MULB
    } state_t;

    typedef enum logic [1:0] {
        SGN_NONE, SGN_ADD, SGN_SUB
    } term_sign_t;

    typedef struct packed {
        logic [1:0] i;
        logic [1:0] j;
        logic [1:0] k;
        term_sign_t sg;
    } coef_plan_t;

    // Axis products and sine term for each row-major coefficient.
    function automatic coef_plan_t coef_plan(input logic [3:0] idx);
        coef_plan_t p;
        begin
            case (idx)
                4'd0:    p = '{2'd0, 2'd0, 2'd0, SGN_NONE};
                4'd1:    p = '{2'd0, 2'd1, 2'd2, SGN_SUB};
                4'd2:    p = '{2'd0, 2'd2, 2'd1, SGN_ADD};
                4'd3:    p = '{2'd0, 2'd1, 2'd2, SGN_ADD};
                4'd4:    p = '{2'd1, 2'd1, 2'd0, SGN_NONE};
                4'd5:    p = '{2'd1, 2'd2, 2'd0, SGN_SUB};
                4'd6:    p = '{2'd0, 2'd2, 2'd1, SGN_SUB};
                4'd7:    p = '{2'd1, 2'd2, 2'd0, SGN_ADD};
                4'd8:    p = '{2'd2, 2'd2, 2'd0, SGN_NONE};
                default: p = '{2'd0, 2'd0, 2'd0, SGN_NONE};
            endcase
            return p;
        end
    endfunction

    state_t                      state_reg;
    logic                        mode_reg;
    logic signed [AXIS_W-1:0]    axis_reg [3];
    logic [ANGLE_W-1:0]          angle_reg;
    logic signed [COORD_WIDTH-1:0] dist_reg;
    logic signed [CORDIC_W-1:0]  x_reg, y_reg, z_reg;
    logic                        neg_reg;
    logic [4:0]                  iter_reg;
    logic signed [CF-1:0]        c_reg, s_reg;
    logic signed [TW-1:0]        t_reg;
    logic [3:0]                  idx_reg;
    logic signed [PW-1:0]        prod_reg;
    logic signed [SPW-1:0]       sp_reg;
    logic signed [CF-1:0]        coef_reg [9];
    logic signed [OW-1:0]        off_reg [3];

    logic signed [14:0]          a1, a2, a3;
    logic                        neg_next;
    logic signed [CORDIC_W-1:0]  z_start;
    logic signed [CORDIC_W-1:0]  dx, dy, atan_v;
    logic signed [CORDIC_W-1:0]  xr, yr, cr, sr, cq, sq;
    coef_plan_t                  plan;
    logic signed [31:0]          pa;
    logic signed [SPW-1:0]       spa;
    logic signed [PW-1:0]        po;
    logic signed [VW-1:0]        pv, sv, cv, vsum, vr, vc;
    logic signed [PW-1:0]        osum;
    logic                        write_ok;

    // Angle folded into the CORDIC's convergence range.
    always_comb begin
        a1 = {2'b00, angle_reg};
        if (a1 >= 15'sd5760) begin
            a1 = a1 - 15'sd5760;
        end
        a2 = (a1 > 15'sd2880) ? a1 - 15'sd5760 : a1;
        a3 = a2;
        neg_next = 1'b0;
        if (a2 > 15'sd1440) begin
            a3 = a2 - 15'sd2880;
            neg_next = 1'b1;
        end else if (a2 < -15'sd1440) begin
            a3 = a2 + 15'sd2880;
            neg_next = 1'b1;
        end
        z_start = {a3[14], a3, 16'b0};
    end

    // One CORDIC micro-rotation.
    assign dx     = x_reg >>> iter_reg;
    assign dy     = y_reg >>> iter_reg;
    assign atan_v = cordic_atan(iter_reg);

    // Sine and cosine rounded and clamped to plus or minus one.
    always_comb begin
        xr = neg_reg ? -x_reg : x_reg;
        yr = neg_reg ? -y_reg : y_reg;
        cr = (xr + RND_C) >>> SH;
        sr = (yr + RND_C) >>> SH;
        cq = (cr > ONE_C) ? ONE_C : ((cr < -ONE_C) ? -ONE_C : cr);
        sq = (sr > ONE_C) ? ONE_C : ((sr < -ONE_C) ? -ONE_C : sr);
    end

    // First multiply step: axis pair product, the sine term and the offset product.
    always_comb begin
        plan = coef_plan(idx_reg);
        pa   = axis_reg[plan.i] * axis_reg[plan.j];
        spa  = axis_reg[plan.k] * s_reg;
        po   = axis_reg[idx_reg[1:0] - 2'd1] * dist_reg;
    end

    // Second step: full coefficient, rounded and clamped, and the rounded offset.
    always_comb begin
        pv = $signed(prod_reg[31:0]) * t_reg;
        sv = VW'(sp_reg) <<< AXIS_FRAC;
        cv = VW'(c_reg) <<< (2 * AXIS_FRAC);
        case (plan.sg)
            SGN_ADD: vsum = pv + sv;
            SGN_SUB: vsum = pv - sv;
            default: vsum = pv + cv;
        endcase
        vr = (vsum + RND_V) >>> (2 * AXIS_FRAC);
        vc = (vr > LIM_HI) ? LIM_HI : ((vr < LIM_LO) ? LIM_LO : vr);
        osum = (prod_reg + RND_P) >>> AXIS_FRAC;
    end

    assign write_ok  = (cfg_index <= REG_DISTANCE);
    assign cfg_ready = (state_reg == ST_IDLE);

    // Sequencer with configuration registers and results.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            mode_reg    <= MODE_ROTATE;
            axis_reg[0] <= '0;
            axis_reg[1] <= '0;
            axis_reg[2] <= AXIS_W'(16384);
            angle_reg   <= '0;
            dist_reg    <= '0;
            iter_reg    <= '0;
            idx_reg     <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (cfg_valid) begin
                        case (cfg_index)
                            REG_MODE:     mode_reg    <= cfg_data[0];
                            REG_AXIS_X:   axis_reg[0] <= cfg_data[AXIS_W-1:0];
                            REG_AXIS_Y:   axis_reg[1] <= cfg_data[AXIS_W-1:0];
                            REG_AXIS_Z:   axis_reg[2] <= cfg_data[AXIS_W-1:0];
                            REG_ANGLE:    angle_reg   <= cfg_data[ANGLE_W-1:0];
                            REG_DISTANCE: dist_reg    <= cfg_data;
                            default:      ;
                        endcase
                        if (write_ok) begin
                            state_reg <= ST_LOAD;
                        end
                    end
                end
                ST_LOAD: begin
                    x_reg     <= CORDIC_W'(CORDIC_START);
                    y_reg     <= '0;
                    z_reg     <= z_start;
                    neg_reg   <= neg_next;
                    iter_reg  <= '0;
                    state_reg <= ST_CORDIC;
                end
                ST_CORDIC: begin
                    if (!z_reg[CORDIC_W-1]) begin
                        x_reg <= x_reg - dy;
                        y_reg <= y_reg + dx;
                        z_reg <= z_reg - atan_v;
                    end else begin
                        x_reg <= x_reg + dy;
                        y_reg <= y_reg - dx;
                        z_reg <= z_reg + atan_v;
                    end
                    iter_reg <= iter_reg + 5'd1;
                    if (iter_reg == 5'(CORDIC_STEPS - 1)) begin
                        state_reg <= ST_ROUND;
                    end
                end
                ST_ROUND: begin
                    c_reg     <= cq[CF-1:0];
                    s_reg     <= sq[CF-1:0];
                    t_reg     <= TW'(ONE_C - cq);
                    idx_reg   <= '0;
                    state_reg <= ST_MULA;
                end
                ST_MULA: begin
                    if (idx_reg < 4'd9) begin
                        prod_reg <= PW'(pa);
                    end else begin
                        prod_reg <= po;
                    end
                    sp_reg    <= spa;
                    state_reg <= ST_MULB;
                end
                ST_MULB: begin
                    if (idx_reg < 4'd9) begin
                        coef_reg[idx_reg] <= vc[CF-1:0];
                    end else begin
                        off_reg[idx_reg[1:0] - 2'd1] <= osum[OW-1:0];
                    end
                    if (idx_reg == 4'd11) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        idx_reg   <= idx_reg + 4'd1;
                        state_reg <= ST_MULA;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Results to the lanes.
    always_comb begin
        for (int n = 0; n < 9; n++) begin
            coef_o[n] = coef_reg[n];
        end
        for (int n = 0; n < 3; n++) begin
            offset_o[n] = off_reg[n];
        end
        status_o.busy = (state_reg != ST_IDLE);
        status_o.mode = mode_reg;
    end

    // A write to a real register starts a rebuild.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_valid && cfg_ready && write_ok) |=> (state_reg == ST_LOAD))
        else $error("rebuild did not start after a register write");

    // The CORDIC counter stays within its step count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CORDIC) |-> (iter_reg < 5'(CORDIC_STEPS)))
        else $error("CORDIC step counter out of range");

    // The coefficient index stays within the twelve results.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MULA || state_reg == ST_MULB) |-> (idx_reg < 4'd12))
        else $error("coefficient index out of range");

endmodule

/* rtl/vrt_lane.sv */
// ----------------------------------------------------------------------------
// vrt_lane
// One output coordinate: three coefficient products or the translated value,
// then the rounded sum clamped to the coordinate range.
// ----------------------------------------------------------------------------
module vrt_lane #(
    parameter int COORD_WIDTH    = vrt_pkg::COORD_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = vrt_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              en1,
    input  logic                              en2,
    input  logic                              mode,
    input  logic [2:0][COEF_FRAC_BITS+1:0]    coef_row,
    input  logic [COORD_WIDTH+1:0]            offset,
    input  logic [2:0][COORD_WIDTH-1:0]       point,
    input  logic [COORD_WIDTH-1:0]            own_point,
    output logic [COORD_WIDTH-1:0]            result,
    output logic                              sat
);
    import vrt_pkg::*;

    localparam int CF = COEF_FRAC_BITS + 2;
    localparam int MW = CF + COORD_WIDTH;
    localparam int SW = MW + 2;
    localparam int TW = COORD_WIDTH + 3;

    localparam logic signed [SW-1:0] RND = SW'(64'd1 << (COEF_FRAC_BITS - 1));
    localparam logic signed [SW-1:0] HI  = SW'((64'd1 << (COORD_WIDTH - 1)) - 64'd1);
    localparam logic signed [SW-1:0] LO  = -SW'(64'd1 << (COORD_WIDTH - 1));

    logic signed [MW-1:0] prod_reg [3];
    logic signed [TW-1:0] tr_reg;
    logic [COORD_WIDTH-1:0] res_reg;
    logic                 sat_reg;
    logic signed [SW-1:0] sum, rot, val;

    // Stage one: products and translation.
    always_ff @(posedge aclk) begin
        if (en1) begin
            for (int j = 0; j < 3; j++) begin
                prod_reg[j] <= $signed(coef_row[j]) * $signed(point[j]);
            end
            tr_reg <= TW'($signed(own_point)) + TW'($signed(offset));
        end
    end

    // Stage two: round, select and clamp.
    always_comb begin
        sum = SW'(prod_reg[0]) + SW'(prod_reg[1]) + SW'(prod_reg[2]) + RND;
        rot = sum >>> COEF_FRAC_BITS;
        val = (mode == MODE_TRANSLATE) ? SW'(tr_reg) : rot;
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            if (val > HI) begin
                res_reg <= HI[COORD_WIDTH-1:0];
                sat_reg <= 1'b1;
            end else if (val < LO) begin
                res_reg <= LO[COORD_WIDTH-1:0];
                sat_reg <= 1'b1;
            end else begin
                res_reg <= val[COORD_WIDTH-1:0];
                sat_reg <= 1'b0;
            end
        end
    end

    assign result = res_reg;
    assign sat    = sat_reg;

endmodule

/* rtl/vertex_rotate_translate_unit.sv */
// ----------------------------------------------------------------------------
// vertex_rotate_translate_unit
// Rotates vertices by an axis-angle matrix or translates them along the axis.
//
//  Channel  Direction  Handshake          Payload
//  s_       in         s_valid/s_ready    s_point_x/y/z, s_in_last
//  m_       out        m_valid/m_ready    m_out_x/y/z, m_saturated, m_out_last
//  cfg_     in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// One vertex per cycle unless the output, a rebuild or a pending write holds it;
// each passes the product stage, then the output register. Reset and each write to
// a real register rebuild the matrix and offsets (CORDIC 20 steps) with s_ready low.
// A register write waits until no vertex is in flight and holds off new vertices.
// A stalled output holds its vertex while the product stage still accepts one.
// ----------------------------------------------------------------------------
module vertex_rotate_translate_unit #(
    parameter int COORD_WIDTH    = vrt_pkg::COORD_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = vrt_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [vrt_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [COORD_WIDTH-1:0]            cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [COORD_WIDTH-1:0]            s_point_x,
    input  logic [COORD_WIDTH-1:0]            s_point_y,
    input  logic [COORD_WIDTH-1:0]            s_point_z,
    input  logic                              s_in_last,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [COORD_WIDTH-1:0]            m_out_x,
    output logic [COORD_WIDTH-1:0]            m_out_y,
    output logic [COORD_WIDTH-1:0]            m_out_z,
    output logic                              m_saturated,
    output logic                              m_out_last
);
    import vrt_pkg::*;

    localparam logic [COORD_WIDTH-1:0] HI_C = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] LO_C = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic [8:0][COEF_FRAC_BITS+1:0] coef;
    logic [2:0][COORD_WIDTH+1:0]    offset;
    build_status_t                  status;
    logic [2:0][COORD_WIDTH-1:0]    point;
    logic [2:0][COORD_WIDTH-1:0]    result;
    logic [2:0]                     sat;
    logic v1_reg, last1_reg, v2_reg, last2_reg;
    logic en1, en2;
    logic pipe_empty;
    logic build_ready;

    // Register writes are taken only with no vertex in flight.
    assign pipe_empty = !v1_reg && !v2_reg;
    assign cfg_ready  = build_ready && pipe_empty;

    vrt_builder #(
        .COORD_WIDTH(COORD_WIDTH), .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_builder (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid && pipe_empty), .cfg_ready(build_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .coef_o(coef), .offset_o(offset), .status_o(status)
    );

    assign point = {s_point_z, s_point_y, s_point_x};

    // Stage advance: each stage moves when the next is free or draining.
    // A pending register write keeps new vertices out.
    assign en2     = v1_reg && (!v2_reg || m_ready);
    assign s_ready = !status.busy && !cfg_valid && (!v1_reg || en2);
    assign en1     = s_valid && s_ready;

    // One lane per output coordinate.
    for (genvar r = 0; r < 3; r++) begin : g_lane
        vrt_lane #(
            .COORD_WIDTH(COORD_WIDTH), .COEF_FRAC_BITS(COEF_FRAC_BITS)
        ) u_lane (
            .aclk(aclk), .en1(en1), .en2(en2), .mode(status.mode),
            .coef_row(coef[3*r+2 -: 3]), .offset(offset[r]),
            .point(point), .own_point(point[r]),
            .result(result[r]), .sat(sat[r])
        );
    end

    // Valid and last tracking through the two stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= 1'b1;
            end else if (en2) begin
                v1_reg <= 1'b0;
            end
            if (en2) begin
                v2_reg <= 1'b1;
            end else if (m_ready) begin
                v2_reg <= 1'b0;
            end
        end
        if (en1) begin
            last1_reg <= s_in_last;
        end
        if (en2) begin
            last2_reg <= last1_reg;
        end
    end

    // Merge the lane flags into the result transaction.
    assign m_valid     = v2_reg;
    assign m_out_x     = result[0];
    assign m_out_y     = result[1];
    assign m_out_z     = result[2];
    assign m_saturated = |sat;
    assign m_out_last  = last2_reg;

    // No vertex enters while the matrix is being rebuilt.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !status.busy)
        else $error("vertex accepted during matrix build");

    // A flagged result has a coordinate at a range limit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_saturated) |->
            (m_out_x == HI_C || m_out_x == LO_C || m_out_y == HI_C ||
             m_out_y == LO_C || m_out_z == HI_C || m_out_z == LO_C))
        else $error("saturation flag without a clipped coordinate");

    // A stage-one vertex moves on whenever the output is free.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && !v2_reg) |-> en2)
        else $error("product stage stalled with an empty output");

endmodule

/* bench/vertex_transform_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_transform_checker
// Watches the configuration, vertex and result channels of the vertex
// transform unit, keeps its own copy of the registers and rotation matrix,
// predicts every transformed vertex and compares it field by field.
// ----------------------------------------------------------------------------
module vertex_transform_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [31:0] s_point_x,
    input  logic [31:0] s_point_y,
    input  logic [31:0] s_point_z,
    input  logic        s_in_last,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_out_x,
    input  logic [31:0] m_out_y,
    input  logic [31:0] m_out_z,
    input  logic        m_saturated,
    input  logic        m_out_last,
    output int          error_count,
    output int          pending_count,
    output int          vertices_checked,
    output int          saturated_seen
);
    import vrt_pkg::*;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        sat;
        logic        last;
    } vertex_result_t;

    logic              mode_q;
    longint            axis_q [3];
    logic [12:0]       angle_q;
    longint            dist_q;
    longint            coef_q [9];
    vertex_result_t    expected_vertices [$];

    // Arithmetic shift right with floor semantics.
    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi, ref bit flag);
        if (v < lo) begin
            flag = 1;
            return lo;
        end
        if (v > hi) begin
            flag = 1;
            return hi;
        end
        return v;
    endfunction

    // Rebuilds the rotation matrix from the CORDIC sine and cosine.
    task automatic rebuild_matrix();
        longint a, cx, cy, cz, dx, dy, c, s, t, cc, w [9];
        bit neg, junk;
        a = longint'(angle_q);
        neg = 0;
        cx = CORDIC_START;
        cy = 0;
        if (a >= FULL_TURN) a -= FULL_TURN;
        if (a > FULL_TURN / 2) a -= FULL_TURN;
        if (a > FULL_TURN / 4) begin
            a -= FULL_TURN / 2;
            neg = 1;
        end else if (a < -(FULL_TURN / 4)) begin
            a += FULL_TURN / 2;
            neg = 1;
        end
        cz = a * 65536;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = floor_shift(cx, i);
            dy = floor_shift(cy, i);
            if (cz >= 0) begin
                cx -= dy; cy += dx; cz -= longint'(cordic_atan(i[4:0]));
            end else begin
                cx += dy; cy -= dx; cz += longint'(cordic_atan(i[4:0]));
            end
        end
        if (neg) begin
            cx = -cx;
            cy = -cy;
        end
        c = clip(floor_shift(cx + (64'sd1 <<< 13), 14), -16384, 16384, junk);
        s = clip(floor_shift(cy + (64'sd1 <<< 13), 14), -16384, 16384, junk);
        t = 16384 - c;
        cc = c <<< 28;
        w[0] = axis_q[0] * axis_q[0] * t + cc;
        w[1] = axis_q[0] * axis_q[1] * t - ((axis_q[2] * s) <<< 14);
        w[2] = axis_q[0] * axis_q[2] * t + ((axis_q[1] * s) <<< 14);
        w[3] = axis_q[0] * axis_q[1] * t + ((axis_q[2] * s) <<< 14);
        w[4] = axis_q[1] * axis_q[1] * t + cc;
        w[5] = axis_q[1] * axis_q[2] * t - ((axis_q[0] * s) <<< 14);
        w[6] = axis_q[0] * axis_q[2] * t - ((axis_q[1] * s) <<< 14);
        w[7] = axis_q[1] * axis_q[2] * t + ((axis_q[0] * s) <<< 14);
        w[8] = axis_q[2] * axis_q[2] * t + cc;
        for (int i = 0; i < 9; i++)
            coef_q[i] = clip(floor_shift(w[i] + (64'sd1 <<< 27), 28), -32768, 32767, junk);
    endtask

    // Predicts the result of one vertex under the current settings.
    function automatic vertex_result_t transform_vertex(logic [31:0] px, logic [31:0] py,
                                                        logic [31:0] pz, logic last);
        vertex_result_t r;
        longint p [3], acc_hi, acc_lo, v, off;
        logic [31:0] o [3];
        bit flag;
        p[0] = longint'(signed'(px));
        p[1] = longint'(signed'(py));
        p[2] = longint'(signed'(pz));
        flag = 0;
        for (int k = 0; k < 3; k++) begin
            if (mode_q == MODE_ROTATE) begin
                acc_hi = 0;
                acc_lo = 0;
                for (int j = 0; j < 3; j++) begin
                    acc_hi += coef_q[k*3+j] * floor_shift(p[j], 24);
                    acc_lo += coef_q[k*3+j] * (p[j] & 64'hFF_FFFF);
                end
                v = (acc_hi <<< 10) + floor_shift(acc_lo + 8192, 14);
            end else begin
                off = floor_shift(axis_q[k] * dist_q + 8192, 14);
                v = p[k] + off;
            end
            o[k] = 32'(clip(v, -64'sd2147483648, 64'sd2147483647, flag));
        end
        r.x = o[0];
        r.y = o[1];
        r.z = o[2];
        r.sat = flag;
        r.last = last;
        return r;
    endfunction

    assign pending_count = expected_vertices.size();

    // Tracks register writes, accepted vertices and accepted results.
    always @(posedge aclk) begin
        vertex_result_t exp_v, got_v, new_v;
        if (!aresetn) begin
            mode_q  = MODE_ROTATE;
            axis_q  = '{0, 0, 16384};
            angle_q = '0;
            dist_q  = 0;
            rebuild_matrix();
            expected_vertices.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_MODE:     mode_q = cfg_data[0];
                    REG_AXIS_X:   axis_q[0] = longint'(signed'(cfg_data[15:0]));
                    REG_AXIS_Y:   axis_q[1] = longint'(signed'(cfg_data[15:0]));
                    REG_AXIS_Z:   axis_q[2] = longint'(signed'(cfg_data[15:0]));
                    REG_ANGLE:    angle_q = cfg_data[12:0];
                    REG_DISTANCE: dist_q = longint'(signed'(cfg_data));
                    default: ;
                endcase
                rebuild_matrix();
            end
            if (s_valid && s_ready) begin
                new_v = transform_vertex(s_point_x, s_point_y, s_point_z, s_in_last);
                expected_vertices = {expected_vertices, new_v};
            end
            if (m_valid && m_ready) begin
                got_v = '{m_out_x, m_out_y, m_out_z, m_saturated, m_out_last};
                if (got_v.sat) saturated_seen++;
                if (expected_vertices.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("ERROR: unexpected result transaction %h", got_v);
                end else begin
                    exp_v = expected_vertices.pop_front();
                    vertices_checked++;
                    if (got_v !== exp_v) begin
                        error_count++;
                        if (error_count <= 10)
                            $display("ERROR: x %h/%h y %h/%h z %h/%h sat %b/%b last %b/%b",
                                     exp_v.x, got_v.x, exp_v.y, got_v.y, exp_v.z, got_v.z,
                                     exp_v.sat, got_v.sat, exp_v.last, got_v.last);
                    end
                end
            end
        end
    end

    initial begin
        error_count = 0;
        vertices_checked = 0;
        saturated_seen = 0;
    end

endmodule

/* bench/vertex_rotate_translate_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_rotate_translate_unit_tb
// Drives vertices and register writes into the vertex transform unit with
// random idling on both channels; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module vertex_rotate_translate_unit_tb;
    import vrt_pkg::*;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [31:0] s_point_x = '0;
    logic [31:0] s_point_y = '0;
    logic [31:0] s_point_z = '0;
    logic        s_in_last = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [31:0] m_out_x, m_out_y, m_out_z;
    logic        m_saturated, m_out_last;
    int          error_count, pending_count, vertices_checked, saturated_seen;
    bit          quiet_tail = 0;
    bit          hold_results = 0;
    int          phase_count = 0;

    always begin
        #10 aclk = 1;
        #10 aclk = 0;
    end

    vertex_rotate_translate_unit u_top (.*);

    vertex_transform_checker u_checker (.*);

    // Offers one vertex, at times with a random idle burst in front of it.
    // Valid stays up across back-to-back transactions; drain() lowers it.
    task automatic send_vertex(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                               logic last);
        int gap;
        cfg_valid <= 0;
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1;
        s_point_x <= px;
        s_point_y <= py;
        s_point_z <= pz;
        s_in_last <= last;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Random coordinate: full range, within +-1000000, or most often within +-1000000000.
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0:       return $urandom();
            1:       return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            default: return 32'($signed($urandom_range(0, 2000000000)) - 1000000000);
        endcase
    endfunction

    // Register write; valid is lowered by the next vertex or by drain().
    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Waits until every vertex has come back and the builder has settled.
    task automatic drain();
        s_valid   <= 0;
        cfg_valid <= 0;
        while (pending_count != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic set_rotation(int ax, int ay, int az, int ang);
        write_reg(REG_MODE, 32'(MODE_ROTATE));
        write_reg(REG_AXIS_X, 32'(ax));
        write_reg(REG_AXIS_Y, 32'(ay));
        write_reg(REG_AXIS_Z, 32'(az));
        write_reg(REG_ANGLE, 32'(ang));
        phase_count++;
    endtask

    task automatic random_vertices(int count);
        for (int i = 0; i < count; i++)
            send_vertex(rand_coord(), rand_coord(), rand_coord(), $urandom_range(0, 1));
    endtask

    // Result side: random stall bursts, none during the tail; ready held low in a hold-off.
    always @(posedge aclk) begin
        int stall_left;
        if (stall_left > 0) begin
            stall_left--;
        end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 12);
        end
        m_ready <= !hold_results && (quiet_tail || stall_left == 0);
    end

    initial begin
        logic [31:0] edge_vals [6];
        edge_vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0001_0000,
                      32'hFFFF_0000};
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        repeat (60) @(posedge aclk);

        // Reset matrix is identity; field extremes pass through.
        for (int i = 0; i < 6; i++)
            send_vertex(edge_vals[i], edge_vals[5 - i], edge_vals[(i + 2) % 6], i[0]);
        drain();

        // Rotations: quarter turn about z, wrap past a full turn, odd axis, max angle.
        set_rotation(0, 0, 16384, 1440);
        for (int i = 0; i < 6; i++)
            send_vertex(edge_vals[i], edge_vals[(i + 1) % 6], 32'h0001_0000, 1);
        drain();
        set_rotation(-16384, 16384, -16384, 8191);
        for (int i = 0; i < 4; i++)
            send_vertex(edge_vals[i], edge_vals[i], edge_vals[i], 0);
        drain();

        // Translation at the distance extremes; unused index is ignored.
        write_reg(REG_MODE, 32'(MODE_TRANSLATE));
        write_reg(REG_DISTANCE, 32'h7FFF_FFFF);
        write_reg(3'd6, 32'hFFFF_FFFF);
        write_reg(3'd7, 32'h0);
        for (int i = 0; i < 3; i++)
            send_vertex(edge_vals[i], edge_vals[i + 1], edge_vals[1], 1);
        drain();
        write_reg(REG_DISTANCE, 32'h8000_0000);
        send_vertex(edge_vals[0], edge_vals[1], edge_vals[0], 0);
        drain();

        // Long receiver hold-off so that the unit fills and stalls its input.
        fork
            begin
                hold_results = 1;
                repeat (200) @(posedge aclk);
                hold_results = 0;
            end
            random_vertices(20);
        join
        drain();

        // Random phases over many settings.
        for (int ph = 0; ph < 16; ph++) begin
            if ($urandom_range(0, 2) == 0) begin
                write_reg(REG_MODE, 32'(MODE_TRANSLATE));
                write_reg(REG_AXIS_X, 32'($urandom_range(0, 32768)) - 32'd16384);
                write_reg(REG_AXIS_Y, $urandom());
                write_reg(REG_AXIS_Z, 32'($urandom_range(0, 32768)) - 32'd16384);
                write_reg(REG_DISTANCE, ($urandom_range(0, 1)) ? $urandom()
                                        : 32'($signed($urandom_range(0, 4000000)) - 2000000));
                phase_count++;
            end else begin
                set_rotation($urandom_range(0, 32768) - 16384, $urandom_range(0, 65535),
                             $urandom_range(0, 32768) - 16384, $urandom_range(0, 8191));
            end
            if (ph == 15) quiet_tail = 1;
            random_vertices(105);
            drain();
        end

        $display("Checked %0d vertices over %0d register settings, %0d saturated.",
                 vertices_checked, phase_count, saturated_seen);
        if (error_count == 0)
            $display("vertex_rotate_translate_unit_tb: done, clean");
        else
            $display("vertex_rotate_translate_unit_tb: done, errors");
        $finish;
    end

    initial begin
        #20ms;
        $display("vertex_rotate_translate_unit_tb: done, errors");
        $finish;
    end

endmodule
